>>> src/bse_pkg.sv
// shared types, constants and fixed-point helpers for the b-spline surface evaluator
// no dependencies; imported by bse_basis, bspline_surface_evaluate_unit and the testbench
`default_nettype none

package bse_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_DEGREE = 3;
    localparam int KNOT_W     = 17;
    localparam int COORD_W    = 32;
    localparam int DEG_W      = 2;
    localparam int LAST_W     = 4;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int ACC_W      = 62;

    localparam logic [KNOT_W-1:0]       KNOT_ONE   = KNOT_W'(1 << FRAC_BITS);
    localparam logic signed [63:0]      S32_MAX_64 = 64'sd2147483647;
    localparam logic signed [63:0]      S32_MIN_64 = -64'sd2147483648;
    localparam logic signed [63:0]      FRAC_ROUND = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    localparam logic signed [ACC_W-1:0] ACC_LIM    = {2'b01, {(ACC_W-2){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_U  = 2'd0,
        CMD_WRITE_V  = 2'd1,
        CMD_WRITE_PT = 2'd2,
        CMD_EVAL     = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_U_DEGREE = 2'd0,
        CFG_V_DEGREE = 2'd1,
        CFG_U_LAST   = 2'd2,
        CFG_V_LAST   = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_LOAD,
        BS_INIT,
        BS_STEP,
        BS_HALF,
        BS_DIV,
        BS_MUL,
        BS_ADD,
        BS_WRITE
    } bs_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASIS,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } top_state_t;

    // request from the top level to one basis unit
    typedef struct packed {
        logic              start;
        logic [DEG_W-1:0]  degree;
        logic [KNOT_W-1:0] param;
    } bs_req_t;

    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX_64)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < S32_MIN_64)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    // divide by 2^FRAC_BITS, truncating toward zero
    function automatic logic signed [63:0] fx_shr(input logic signed [63:0] x);
        logic signed [63:0] r;
        if (x[63])
        begin
            r = (x + FRAC_ROUND) >>> FRAC_BITS;
        end
        else
        begin
            r = x >>> FRAC_BITS;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/bse_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
`default_nettype none

module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/bse_basis.sv
// cox-de boor basis unit for one direction: knot line, basis line, serial divider
// depends on bse_pkg; reads its knot list from an external bse_ram
`default_nettype none

module bse_basis #(
    parameter int MAX_CTRL_PER_DIR = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire bse_pkg::bs_req_t                       req,
    input  wire logic [$clog2(MAX_CTRL_PER_DIR)-1:0]    last,
    output logic      [$clog2(MAX_CTRL_PER_DIR+2)-1:0]  knot_addr,
    input  wire logic [bse_pkg::KNOT_W-1:0]             knot_data,
    output logic                                        done,
    output logic signed [bse_pkg::COORD_W-1:0]          basis_line [MAX_CTRL_PER_DIR]
);

    import bse_pkg::*;

    localparam int KA_W     = $clog2(MAX_CTRL_PER_DIR + 2);
    localparam int LINE_LEN = MAX_CTRL_PER_DIR + MAX_DEGREE + 2;
    localparam int POS_W    = $clog2(LINE_LEN + 1);
    localparam int CMP_W    = POS_W + 1;
    localparam int IDX_W    = $clog2(MAX_CTRL_PER_DIR);
    localparam int DIFF_W   = KNOT_W + 1;
    localparam int NUM_W    = KNOT_W + FRAC_BITS;
    localparam int QCNT_W   = $clog2(NUM_W + 1);

    bs_state_t state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [DEG_W-1:0]  d_reg, d_next;
    logic              half_reg, half_next;
    logic              done_reg, done_next;
    logic              ld_valid_reg, ld_valid_next;
    logic              ld_zero_reg, ld_zero_next;
    logic              ld_one_reg, ld_one_next;
    logic              ld_last_reg, ld_last_next;
    logic [QCNT_W-1:0] dcnt_reg, dcnt_next;

    logic [DEG_W-1:0]         p_reg, p_next;
    logic [IDX_W-1:0]         m_reg, m_next;
    logic [KNOT_W-1:0]        u_reg, u_next;
    logic [KNOT_W-1:0]        lastk_reg, lastk_next;
    logic signed [32:0]       sum_reg, sum_next;
    logic signed [31:0]       ratio_reg, ratio_next;
    logic signed [63:0]       prod_reg, prod_next;
    logic [NUM_W-1:0]         quo_reg, quo_next;
    logic [KNOT_W-1:0]        rem_reg, rem_next;
    logic [KNOT_W-1:0]        den_reg, den_next;
    logic                     neg_reg, neg_next;

    logic [KNOT_W-1:0]        kv_line_reg [LINE_LEN];
    logic signed [31:0]       nb_line_reg [LINE_LEN];
    logic                     kv_shift, nb_shift;
    logic [KNOT_W-1:0]        kv_in;
    logic signed [31:0]       nb_in;

    logic [KNOT_W-1:0]        kv0, kv1, kvd, kvd1, ld_val;
    logic [CMP_W-1:0]         pos_ext, mp;
    logic signed [DIFF_W-1:0] a_num, a_den, b_num, b_den, h_num, h_den;
    logic signed [31:0]       h_nb, term;
    logic [KNOT_W:0]          div_shifted;
    logic                     div_ge, advance, in_span;
    logic signed [NUM_W:0]    q_mag, q_sig;

    // taps for the current degree pass
    always_comb
    begin
        kv0  = kv_line_reg[0];
        kv1  = kv_line_reg[1];
        kvd  = kv_line_reg[1];
        kvd1 = kv_line_reg[2];
        for (int k = 1; k <= MAX_DEGREE; k++)
        begin
            if (d_reg == DEG_W'(k))
            begin
                kvd  = kv_line_reg[k];
                kvd1 = kv_line_reg[k+1];
            end
        end
    end

    assign pos_ext = CMP_W'(pos_reg);
    assign mp      = CMP_W'(m_reg) + CMP_W'(p_reg);
    assign a_num   = $signed({1'b0, u_reg}) - $signed({1'b0, kv0});
    assign a_den   = $signed({1'b0, kvd}) - $signed({1'b0, kv0});
    assign b_num   = $signed({1'b0, kvd1}) - $signed({1'b0, u_reg});
    assign b_den   = $signed({1'b0, kvd1}) - $signed({1'b0, kv1});
    assign h_num   = half_reg ? b_num : a_num;
    assign h_den   = half_reg ? b_den : a_den;
    assign h_nb    = half_reg ? nb_line_reg[1] : nb_line_reg[0];
    assign ld_val  = ld_zero_reg ? '0 : (ld_one_reg ? KNOT_ONE : knot_data);
    assign term    = sat_s32(fx_shr(prod_reg));
    assign in_span = (kv0 <= u_reg && u_reg < kv1)
                  || (u_reg == lastk_reg && kv0 < kv1 && kv1 == lastk_reg);

    assign div_shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign div_ge      = div_shifted >= {1'b0, den_reg};
    assign q_mag       = $signed({1'b0, quo_reg});
    assign q_sig       = neg_reg ? -q_mag : q_mag;

    assign knot_addr = KA_W'(pos_reg - POS_W'(p_reg));

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        d_next        = d_reg;
        half_next     = half_reg;
        done_next     = done_reg;
        ld_valid_next = 1'b0;
        ld_zero_next  = ld_zero_reg;
        ld_one_next   = ld_one_reg;
        ld_last_next  = ld_last_reg;
        dcnt_next     = dcnt_reg;
        p_next        = p_reg;
        m_next        = m_reg;
        u_next        = u_reg;
        lastk_next    = lastk_reg;
        sum_next      = sum_reg;
        ratio_next    = ratio_reg;
        prod_next     = prod_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        neg_next      = neg_reg;
        kv_shift      = 1'b0;
        kv_in         = kv_line_reg[0];
        nb_shift      = 1'b0;
        nb_in         = nb_line_reg[0];
        advance       = 1'b0;

        unique case (state_reg)
            BS_IDLE:
            begin
                if (req.start)
                begin
                    p_next     = req.degree;
                    m_next     = last;
                    u_next     = req.param;
                    done_next  = 1'b0;
                    pos_next   = '0;
                    state_next = BS_LOAD;
                end
            end
            BS_LOAD:
            begin
                // issue one knot read a cycle, shift the returned value in on the cycle after
                if (ld_valid_reg)
                begin
                    kv_shift = 1'b1;
                    kv_in    = ld_val;
                    if (ld_last_reg)
                    begin
                        lastk_next = ld_val;
                    end
                end
                if (pos_reg == POS_W'(LINE_LEN))
                begin
                    pos_next   = '0;
                    state_next = BS_INIT;
                end
                else
                begin
                    ld_valid_next = 1'b1;
                    ld_zero_next  = pos_ext < CMP_W'(p_reg);
                    ld_one_next   = pos_ext > CMP_W'(m_reg) + CMP_W'(1);
                    ld_last_next  = pos_ext == mp + CMP_W'(1);
                    pos_next      = pos_reg + POS_W'(1);
                end
            end
            BS_INIT:
            begin
                kv_shift = 1'b1;
                nb_shift = 1'b1;
                nb_in    = (pos_ext <= mp && in_span) ? 32'(signed'({1'b0, KNOT_ONE})) : '0;
                if (pos_reg == POS_W'(LINE_LEN - 1))
                begin
                    pos_next = '0;
                    if (p_reg == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = BS_IDLE;
                    end
                    else
                    begin
                        d_next     = DEG_W'(1);
                        state_next = BS_STEP;
                    end
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            BS_STEP:
            begin
                if (pos_ext + CMP_W'(d_reg) > mp)
                begin
                    // beyond this pass: entry keeps its value
                    kv_shift = 1'b1;
                    nb_shift = 1'b1;
                    advance  = 1'b1;
                end
                else if (u_reg < kv0 || u_reg > kvd1
                         || (nb_line_reg[0] == '0 && nb_line_reg[1] == '0))
                begin
                    kv_shift = 1'b1;
                    nb_shift = 1'b1;
                    nb_in    = '0;
                    advance  = 1'b1;
                end
                else
                begin
                    sum_next   = '0;
                    half_next  = 1'b0;
                    state_next = BS_HALF;
                end
            end
            BS_HALF:
            begin
                if (h_nb == '0 || h_den == '0)
                begin
                    if (half_reg)
                    begin
                        state_next = BS_WRITE;
                    end
                    else
                    begin
                        half_next = 1'b1;
                    end
                end
                else
                begin
                    quo_next   = {(h_num[DIFF_W-1] ? KNOT_W'(-h_num) : KNOT_W'(h_num)),
                                  {FRAC_BITS{1'b0}}};
                    den_next   = h_den[DIFF_W-1] ? KNOT_W'(-h_den) : KNOT_W'(h_den);
                    neg_next   = h_num[DIFF_W-1] ^ h_den[DIFF_W-1];
                    rem_next   = '0;
                    dcnt_next  = QCNT_W'(NUM_W);
                    state_next = BS_DIV;
                end
            end
            BS_DIV:
            begin
                if (dcnt_reg != '0)
                begin
                    rem_next  = div_ge ? KNOT_W'(div_shifted - {1'b0, den_reg})
                                       : div_shifted[KNOT_W-1:0];
                    quo_next  = {quo_reg[NUM_W-2:0], div_ge};
                    dcnt_next = dcnt_reg - QCNT_W'(1);
                end
                else
                begin
                    ratio_next = sat_s32({{(64-NUM_W-1){q_sig[NUM_W]}}, q_sig});
                    state_next = BS_MUL;
                end
            end
            BS_MUL:
            begin
                prod_next  = ratio_reg * h_nb;
                state_next = BS_ADD;
            end
            BS_ADD:
            begin
                sum_next = sum_reg + {term[31], term};
                if (half_reg)
                begin
                    state_next = BS_WRITE;
                end
                else
                begin
                    half_next  = 1'b1;
                    state_next = BS_HALF;
                end
            end
            BS_WRITE:
            begin
                kv_shift = 1'b1;
                nb_shift = 1'b1;
                nb_in    = sat_s32({{31{sum_reg[32]}}, sum_reg});
                advance  = 1'b1;
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase

        if (advance)
        begin
            if (pos_reg == POS_W'(LINE_LEN - 1))
            begin
                pos_next = '0;
                if (d_reg == p_reg)
                begin
                    done_next  = 1'b1;
                    state_next = BS_IDLE;
                end
                else
                begin
                    d_next     = d_reg + DEG_W'(1);
                    state_next = BS_STEP;
                end
            end
            else
            begin
                pos_next   = pos_reg + POS_W'(1);
                state_next = BS_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BS_IDLE;
            pos_reg      <= '0;
            d_reg        <= '0;
            half_reg     <= 1'b0;
            done_reg     <= 1'b0;
            ld_valid_reg <= 1'b0;
            ld_zero_reg  <= 1'b0;
            ld_one_reg   <= 1'b0;
            ld_last_reg  <= 1'b0;
            dcnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            d_reg        <= d_next;
            half_reg     <= half_next;
            done_reg     <= done_next;
            ld_valid_reg <= ld_valid_next;
            ld_zero_reg  <= ld_zero_next;
            ld_one_reg   <= ld_one_next;
            ld_last_reg  <= ld_last_next;
            dcnt_reg     <= dcnt_next;
        end
    end

    // lines rotate so every tap sits at a fixed place
    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        m_reg     <= m_next;
        u_reg     <= u_next;
        lastk_reg <= lastk_next;
        sum_reg   <= sum_next;
        ratio_reg <= ratio_next;
        prod_reg  <= prod_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        if (kv_shift)
        begin
            for (int k = 0; k < LINE_LEN - 1; k++)
            begin
                kv_line_reg[k] <= kv_line_reg[k+1];
            end
            kv_line_reg[LINE_LEN-1] <= kv_in;
        end
        if (nb_shift)
        begin
            for (int k = 0; k < LINE_LEN - 1; k++)
            begin
                nb_line_reg[k] <= nb_line_reg[k+1];
            end
            nb_line_reg[LINE_LEN-1] <= nb_in;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_CTRL_PER_DIR; k++)
        begin
            basis_line[k] = nb_line_reg[k];
        end
    end

`ifndef SYNTHESIS
    a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_DIV && dcnt_reg != '0) |-> den_reg != '0)
        else $error("divider running on a zero denominator");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == BS_IDLE)
        else $error("basis flagged done while still busy");

    a_step_degree: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BS_STEP |-> (d_reg != '0 && d_reg <= p_reg))
        else $error("recursion pass outside degree range");
`endif

endmodule

`default_nettype wire

>>> src/bspline_surface_evaluate_unit.sv
// top level of the tensor-product b-spline surface evaluator
// depends on bse_pkg, bse_ram and bse_basis
`default_nettype none

// Evaluates one surface point per evaluate beat (cmd 3) and loads the u and v
// interior knot lists (cmd 0, 1) and the control point grid (cmd 2) otherwise.
// Knots and points live in three rams with registered read; write beats give no
// result. An evaluate beat runs both basis units side by side: each loads its
// clamped knot line, then makes degree+1 passes over it, and every basis term
// with a nonzero input costs up to two serial divides, each followed by a
// multiply and an add, and then a write of the term. The multiply-accumulate
// then reads the (m+1)*(n+1) control points one per cycle, drains its pipeline
// and loads the result; unsorted knots that put the parameter in several spans
// add basis terms and so lengthen an evaluate. Input is taken only while the
// sequencer is idle; the result sits in an output register, so the next beat may
// be taken while it waits. Knots and points that were never written read as
// undefined. Out of range knot or point indexes are dropped on write.

module bspline_surface_evaluate_unit #(
    parameter int MAX_CTRL_PER_DIR = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_write,
    input  wire logic [bse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bse_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [bse_pkg::CMD_W-1:0]          cmd,
    input  wire logic [4:0]                         knot_index,
    input  wire logic [bse_pkg::KNOT_W-1:0]         knot_value,
    input  wire logic [3:0]                         row_index,
    input  wire logic [3:0]                         col_index,
    input  wire logic signed [bse_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [bse_pkg::COORD_W-1:0] point_y,
    input  wire logic signed [bse_pkg::COORD_W-1:0] point_z,
    input  wire logic [bse_pkg::KNOT_W-1:0]         param_u,
    input  wire logic [bse_pkg::KNOT_W-1:0]         param_v,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [bse_pkg::COORD_W-1:0]      surf_x,
    output logic signed [bse_pkg::COORD_W-1:0]      surf_y,
    output logic signed [bse_pkg::COORD_W-1:0]      surf_z
);

    import bse_pkg::*;

    localparam int KNOT_DEPTH = MAX_CTRL_PER_DIR + 2;
    localparam int KA_W       = $clog2(KNOT_DEPTH);
    localparam int IDX_W      = $clog2(MAX_CTRL_PER_DIR);
    localparam int CP_DEPTH   = MAX_CTRL_PER_DIR * MAX_CTRL_PER_DIR;
    localparam int CP_AW      = $clog2(CP_DEPTH);
    localparam int PT_W       = 3 * COORD_W;

    // configuration
    logic [DEG_W-1:0]  u_degree_reg, v_degree_reg;
    logic [LAST_W-1:0] u_last_reg, v_last_reg;

    // sequencer
    top_state_t state_reg, state_next;
    logic [IDX_W-1:0] ci_reg, ci_next, cj_reg, cj_next;
    logic [IDX_W-1:0] m_clamp, n_clamp;
    logic             in_acc, eval_start, issue, out_load;
    logic             out_valid_reg, out_valid_next;

    // memories
    logic             u_we, v_we, cp_we;
    logic [KA_W-1:0]  knot_waddr, u_raddr, v_raddr;
    logic [KNOT_W-1:0] u_rdata, v_rdata;
    logic [CP_AW-1:0] cp_waddr, cp_raddr;
    logic [PT_W-1:0]  cp_rdata;

    // basis units
    bs_req_t          u_req, v_req;
    logic             u_done, v_done;
    logic signed [COORD_W-1:0] u_line [MAX_CTRL_PER_DIR];
    logic signed [COORD_W-1:0] v_line [MAX_CTRL_PER_DIR];

    // multiply-accumulate pipeline
    logic                      s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [63:0]        wprod_reg;
    logic signed [COORD_W-1:0] w_reg;
    logic [PT_W-1:0]           pt_reg;
    logic signed [63:0]        prod_reg [3];
    logic signed [ACC_W-1:0]   acc_reg [3];
    logic signed [COORD_W-1:0] surf_reg [3];
    logic signed [ACC_W:0]     acc_sum [3];
    logic signed [ACC_W-1:0]   acc_clamp [3];
    logic signed [63:0]        term_full [3];

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign eval_start = in_acc && (cmd == CMD_EVAL);

    // configuration writes, masked to register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_degree_reg <= DEG_W'(3);
            v_degree_reg <= DEG_W'(3);
            u_last_reg   <= LAST_W'(15);
            v_last_reg   <= LAST_W'(15);
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_U_DEGREE: u_degree_reg <= cfg_data[DEG_W-1:0];
                CFG_V_DEGREE: v_degree_reg <= cfg_data[DEG_W-1:0];
                CFG_U_LAST:   u_last_reg   <= cfg_data[LAST_W-1:0];
                CFG_V_LAST:   v_last_reg   <= cfg_data[LAST_W-1:0];
                default:      u_last_reg   <= u_last_reg;
            endcase
        end
    end

    // last index clamps to the grid size
    assign m_clamp = (u_last_reg < MAX_CTRL_PER_DIR) ? IDX_W'(u_last_reg)
                                                     : IDX_W'(MAX_CTRL_PER_DIR - 1);
    assign n_clamp = (v_last_reg < MAX_CTRL_PER_DIR) ? IDX_W'(v_last_reg)
                                                     : IDX_W'(MAX_CTRL_PER_DIR - 1);

    // store writes; out of range indexes are dropped
    assign knot_waddr = KA_W'(knot_index);
    assign u_we  = in_acc && (cmd == CMD_WRITE_U) && (knot_index < KNOT_DEPTH);
    assign v_we  = in_acc && (cmd == CMD_WRITE_V) && (knot_index < KNOT_DEPTH);
    assign cp_we = in_acc && (cmd == CMD_WRITE_PT)
                && (row_index < MAX_CTRL_PER_DIR) && (col_index < MAX_CTRL_PER_DIR);
    assign cp_waddr = CP_AW'(int'(row_index) * MAX_CTRL_PER_DIR + int'(col_index));
    assign cp_raddr = CP_AW'(int'(ci_reg) * MAX_CTRL_PER_DIR + int'(cj_reg));

    bse_ram #(
        .WIDTH (KNOT_W),
        .DEPTH (KNOT_DEPTH)
    ) u_knot_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (knot_waddr),
        .wdata (knot_value),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    bse_ram #(
        .WIDTH (KNOT_W),
        .DEPTH (KNOT_DEPTH)
    ) v_knot_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (knot_waddr),
        .wdata (knot_value),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    bse_ram #(
        .WIDTH (PT_W),
        .DEPTH (CP_DEPTH)
    ) ctrl_point_ram (
        .clk   (clk),
        .we    (cp_we),
        .waddr (cp_waddr),
        .wdata ({point_z, point_y, point_x}),
        .raddr (cp_raddr),
        .rdata (cp_rdata)
    );

    assign u_req.start  = eval_start;
    assign u_req.degree = u_degree_reg;
    assign u_req.param  = param_u;
    assign v_req.start  = eval_start;
    assign v_req.degree = v_degree_reg;
    assign v_req.param  = param_v;

    bse_basis #(
        .MAX_CTRL_PER_DIR (MAX_CTRL_PER_DIR)
    ) u_basis (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (u_req),
        .last       (m_clamp),
        .knot_addr  (u_raddr),
        .knot_data  (u_rdata),
        .done       (u_done),
        .basis_line (u_line)
    );

    bse_basis #(
        .MAX_CTRL_PER_DIR (MAX_CTRL_PER_DIR)
    ) v_basis (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (v_req),
        .last       (n_clamp),
        .knot_addr  (v_raddr),
        .knot_data  (v_rdata),
        .done       (v_done),
        .basis_line (v_line)
    );

    // sequencer: basis, then one control point per cycle, then drain, then result
    always_comb
    begin
        state_next     = state_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        issue          = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (eval_start)
                begin
                    ci_next    = '0;
                    cj_next    = '0;
                    state_next = ST_BASIS;
                end
            end
            ST_BASIS:
            begin
                if (u_done && v_done)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                issue = 1'b1;
                if (cj_reg == n_clamp)
                begin
                    cj_next = '0;
                    if (ci_reg == m_clamp)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        ci_next = ci_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    cj_next = cj_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!(s1_valid_reg || s2_valid_reg || s3_valid_reg))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ci_reg        <= '0;
            cj_reg        <= '0;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ci_reg        <= ci_next;
            cj_reg        <= cj_next;
            out_valid_reg <= out_valid_next;
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
        end
    end

    // accumulate with clamp to +-2^60 after each add
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            term_full[c] = fx_shr(prod_reg[c]);
            acc_sum[c]   = {acc_reg[c][ACC_W-1], acc_reg[c]}
                         + {term_full[c][ACC_W-1], term_full[c][ACC_W-1:0]};
            if (acc_sum[c] > $signed({ACC_LIM[ACC_W-1], ACC_LIM}))
            begin
                acc_clamp[c] = ACC_LIM;
            end
            else if (acc_sum[c] < -$signed({ACC_LIM[ACC_W-1], ACC_LIM}))
            begin
                acc_clamp[c] = -ACC_LIM;
            end
            else
            begin
                acc_clamp[c] = acc_sum[c][ACC_W-1:0];
            end
        end
    end

    // stage 1 weight product, stage 2 weight and point, stage 3 coordinate products
    always_ff @(posedge clk)
    begin
        wprod_reg <= u_line[ci_reg] * v_line[cj_reg];
        w_reg     <= sat_s32(fx_shr(wprod_reg));
        pt_reg    <= cp_rdata;
        for (int c = 0; c < 3; c++)
        begin
            prod_reg[c] <= $signed(pt_reg[c*COORD_W +: COORD_W]) * w_reg;
            if (eval_start)
            begin
                acc_reg[c] <= '0;
            end
            else if (s3_valid_reg)
            begin
                acc_reg[c] <= acc_clamp[c];
            end
            if (out_load)
            begin
                surf_reg[c] <= sat_s32({{(64-ACC_W){acc_reg[c][ACC_W-1]}}, acc_reg[c]});
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign surf_x    = surf_reg[0];
    assign surf_y    = surf_reg[1];
    assign surf_z    = surf_reg[2];

`ifndef SYNTHESIS
    a_mac_after_basis: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC |-> (u_done && v_done))
        else $error("control point sweep started before basis lines were ready");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result beat raised outside the finish step");

    a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !(s1_valid_reg || s2_valid_reg || s3_valid_reg))
        else $error("accumulate pipeline busy while sequencer idle");
`endif

endmodule

`default_nettype wire

>>> tb/tb_bspline_surface_evaluate_unit.sv
// testbench for bspline_surface_evaluate_unit: loads knots and control points, runs
// evaluate beats under random idling and checks every surface point against a local predictor
// depends on bse_pkg and the rtl of bspline_surface_evaluate_unit
`default_nettype none

module tb_bspline_surface_evaluate_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bse_pkg::*;

    localparam int  GRID        = 16;
    localparam int  KNOT_SLOTS  = GRID + 2;
    localparam int  KV_MAX      = GRID + MAX_DEGREE + 2;
    localparam int  BEAT_TARGET = 1350;
    localparam int  CYCLE_LIMIT = 20000000;
    localparam int  SETTLE      = 80;
    localparam longint ONE_Q    = 64'sd65536;
    localparam longint S32_HI   = 64'sd2147483647;
    localparam longint S32_LO   = -64'sd2147483648;
    localparam longint ACC_CAP  = 64'sd1 <<< 60;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } surf_pt_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [CMD_W-1:0] cmd = '0;
    logic [4:0] knot_index = '0;
    logic [KNOT_W-1:0] knot_value = '0;
    logic [3:0] row_index = '0;
    logic [3:0] col_index = '0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] point_z = '0;
    logic [KNOT_W-1:0] param_u = '0;
    logic [KNOT_W-1:0] param_v = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] surf_x;
    logic signed [31:0] surf_y;
    logic signed [31:0] surf_z;

    // predictor copy of the block state
    int     deg_u = 3;
    int     deg_v = 3;
    int     last_u = 15;
    int     last_v = 15;
    longint u_knots [KNOT_SLOTS];
    longint v_knots [KNOT_SLOTS];
    longint grid_x [GRID*GRID];
    longint grid_y [GRID*GRID];
    longint grid_z [GRID*GRID];

    surf_pt_t expected_points [$];
    int  beats_sent = 0;
    int  mismatches = 0;
    int  cycles = 0;
    bit  calm = 1'b0;     // no idling on either side while set

    always #2 clk = ~clk;

    bspline_surface_evaluate_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .knot_index(knot_index), .knot_value(knot_value),
        .row_index(row_index), .col_index(col_index),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .param_u(param_u), .param_v(param_v),
        .out_valid(out_valid), .out_stall(out_stall),
        .surf_x(surf_x), .surf_y(surf_y), .surf_z(surf_z)
    );

    // ---------------------------------------------------------------
    // fixed point predictor
    // ---------------------------------------------------------------
    function automatic longint clip32(input longint v);
        if (v > S32_HI)
        begin
            return S32_HI;
        end
        if (v < S32_LO)
        begin
            return S32_LO;
        end
        return v;
    endfunction

    // zero denominator gives a zero ratio
    function automatic longint ratio_q(input longint num, input longint den);
        if (den == 0)
        begin
            return 0;
        end
        return clip32((num * ONE_Q) / den);
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        return clip32((a * b) / ONE_Q);
    endfunction

    // cox-de boor on the clamped knot line; first m+1 terms are the basis
    function automatic void blend_terms(input longint knots [KNOT_SLOTS], input int p,
                                        input int m, input longint t,
                                        output longint nb [KV_MAX]);
        longint kv [KV_MAX];
        longint lastk;
        longint a;
        longint b;
        int len;
        bit hit;
        len = m + p + 2;
        for (int k = 0; k < KV_MAX; k++)
        begin
            nb[k] = 0;
            kv[k] = 0;
        end
        for (int k = 0; k < len; k++)
        begin
            if (k < p)
            begin
                kv[k] = 0;
            end
            else if (k > m + 1)
            begin
                kv[k] = ONE_Q;
            end
            else
            begin
                kv[k] = knots[k - p];
            end
        end
        lastk = kv[len - 1];
        // half-open span, closed only at the last knot
        for (int i = 0; i <= m + p; i++)
        begin
            hit = (kv[i] <= t && t < kv[i + 1]) ||
                  (t == lastk && kv[i] < kv[i + 1] && kv[i + 1] == lastk);
            nb[i] = hit ? ONE_Q : 0;
        end
        for (int d = 1; d <= p; d++)
        begin
            for (int i = 0; i <= m + p - d; i++)
            begin
                if (t < kv[i] || t > kv[i + d + 1])
                begin
                    nb[i] = 0;
                end
                else
                begin
                    a = ratio_q(t - kv[i], kv[i + d] - kv[i]);
                    b = ratio_q(kv[i + d + 1] - t, kv[i + d + 1] - kv[i + 1]);
                    nb[i] = clip32(mul_q(a, nb[i]) + mul_q(b, nb[i + 1]));
                end
            end
        end
    endfunction

    function automatic surf_pt_t surface_at(input longint pu, input longint pv);
        longint nu [KV_MAX];
        longint nv [KV_MAX];
        longint acc [3];
        longint w;
        longint pt [3];
        surf_pt_t r;
        blend_terms(u_knots, deg_u, last_u, pu, nu);
        blend_terms(v_knots, deg_v, last_v, pv, nv);
        acc[0] = 0;
        acc[1] = 0;
        acc[2] = 0;
        for (int i = 0; i <= last_u; i++)
        begin
            for (int j = 0; j <= last_v; j++)
            begin
                w = mul_q(nu[i], nv[j]);
                pt[0] = grid_x[i*GRID + j];
                pt[1] = grid_y[i*GRID + j];
                pt[2] = grid_z[i*GRID + j];
                for (int c = 0; c < 3; c++)
                begin
                    acc[c] += (pt[c] * w) / ONE_Q;
                    if (acc[c] > ACC_CAP)
                    begin
                        acc[c] = ACC_CAP;
                    end
                    if (acc[c] < -ACC_CAP)
                    begin
                        acc[c] = -ACC_CAP;
                    end
                end
            end
        end
        r.x = 32'(clip32(acc[0]));
        r.y = 32'(clip32(acc[1]));
        r.z = 32'(clip32(acc[2]));
        return r;
    endfunction

    // ---------------------------------------------------------------
    // beat driver: payload held while stalled, prediction on accept
    // ---------------------------------------------------------------
    task automatic send_beat(input cmd_t c, input int kidx, input longint kval,
                             input int r, input int col, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input longint pu, input longint pv);
        if (!calm && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        knot_index <= kidx[4:0];
        knot_value <= kval[KNOT_W-1:0];
        row_index  <= r[3:0];
        col_index  <= col[3:0];
        point_x    <= px;
        point_y    <= py;
        point_z    <= pz;
        param_u    <= pu[KNOT_W-1:0];
        param_v    <= pv[KNOT_W-1:0];
        do @(posedge clk); while (in_stall);
        beats_sent++;
        case (c)
            CMD_WRITE_U:
            begin
                if (kidx < KNOT_SLOTS)
                begin
                    u_knots[kidx] = kval;
                end
            end
            CMD_WRITE_V:
            begin
                if (kidx < KNOT_SLOTS)
                begin
                    v_knots[kidx] = kval;
                end
            end
            CMD_WRITE_PT:
            begin
                grid_x[r*GRID + col] = longint'(signed'(px));
                grid_y[r*GRID + col] = longint'(signed'(py));
                grid_z[r*GRID + col] = longint'(signed'(pz));
            end
            default:
            begin
                expected_points.push_back(surface_at(pu, pv));
            end
        endcase
    endtask

    task automatic write_knot(input bit along_v, input int kidx, input longint kval);
        send_beat(along_v ? CMD_WRITE_V : CMD_WRITE_U, kidx, kval, $urandom_range(15),
                  $urandom_range(15), $urandom, $urandom, $urandom, $urandom_range(65536),
                  $urandom_range(65536));
    endtask

    task automatic write_point(input int r, input int col, input logic [31:0] px,
                               input logic [31:0] py, input logic [31:0] pz);
        send_beat(CMD_WRITE_PT, $urandom_range(31), $urandom_range(65536), r, col,
                  px, py, pz, $urandom_range(65536), $urandom_range(65536));
    endtask

    task automatic evaluate(input longint pu, input longint pv);
        send_beat(CMD_EVAL, $urandom_range(31), $urandom_range(65536), $urandom_range(15),
                  $urandom_range(15), $urandom, $urandom, $urandom, pu, pv);
    endtask

    // drop valid and let every expected surface point come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // register writes only while the block is idle
    task automatic set_config(input int du, input int dv, input int lu, input int lv);
        int vals [4];
        vals = '{du, dv, lu, lv};
        drain_results();
        for (int k = 0; k < 4; k++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= cfg_idx_t'(k);
            cfg_data  <= vals[k][CFG_DATA_W-1:0];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        deg_u  = du;
        deg_v  = dv;
        last_u = lu;
        last_v = lv;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            return $urandom;
        end
        if (sel == 1)
        begin
            return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
        end
        return 32'($signed($urandom_range(2097152)) - 1048576);
    endfunction

    // knot list: 0 sorted, 1 sorted with repeats, 2 unsorted
    task automatic load_knots(input bit along_v, input int style);
        longint ks [KNOT_SLOTS];
        for (int k = 0; k < KNOT_SLOTS; k++)
        begin
            ks[k] = $urandom_range(65536);
            if (style == 1 && k > 0 && $urandom_range(2) == 0)
            begin
                ks[k] = ks[k - 1];
            end
        end
        if (style != 2)
        begin
            ks.sort();
        end
        if (style == 1)
        begin
            ks[0] = 0;
            ks[KNOT_SLOTS - 1] = ONE_Q;
        end
        for (int k = 0; k < KNOT_SLOTS; k++)
        begin
            write_knot(along_v, k, ks[k]);
        end
    endtask

    function automatic longint pick_param(input bit along_v);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            return 0;
        end
        if (sel == 1)
        begin
            return ONE_Q;
        end
        if (sel == 2)
        begin
            return along_v ? v_knots[$urandom_range(KNOT_SLOTS - 1)]
                           : u_knots[$urandom_range(KNOT_SLOTS - 1)];
        end
        return $urandom_range(65536);
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // every knot and control point written before any evaluate
    task automatic test_fill_stores();
        for (int k = 0; k < KNOT_SLOTS; k++)
        begin
            write_knot(1'b0, k, (k * ONE_Q) / (KNOT_SLOTS - 1));
            write_knot(1'b1, k, (k * ONE_Q) / (KNOT_SLOTS - 1));
        end
        for (int r = 0; r < GRID; r++)
        begin
            for (int col = 0; col < GRID; col++)
            begin
                write_point(r, col, rand_coord(), rand_coord(), rand_coord());
            end
        end
    endtask

    // corners of the parameter square, coordinate extremes, dropped knot writes
    task automatic test_directed_corners();
        write_point(0, 0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        write_point(15, 15, 32'h80000000, 32'h7FFFFFFF, 32'h00000001);
        evaluate(0, 0);
        evaluate(ONE_Q, ONE_Q);
        evaluate(0, ONE_Q);
        evaluate(ONE_Q, 0);
        evaluate(32768, 32768);
        evaluate(131071 & ONE_Q, 1);
        evaluate(u_knots[5], v_knots[9]);
        // out of range knot index is dropped
        write_knot(1'b0, 31, 17'h1FFFF);
        write_knot(1'b1, KNOT_SLOTS, 12345);
        evaluate(65535, 21845);
    endtask

    // degree and grid-size extremes, last index below degree included
    task automatic test_config_extremes();
        int sets [5][4];
        sets = '{'{1, 1, 1, 1}, '{3, 3, 1, 1}, '{1, 3, 15, 2},
                 '{3, 1, 2, 15}, '{2, 2, 3, 3}};
        for (int s = 0; s < 5; s++)
        begin
            set_config(sets[s][0], sets[s][1], sets[s][2], sets[s][3]);
            repeat (3) evaluate(pick_param(1'b0), pick_param(1'b1));
            evaluate(0, ONE_Q);
        end
    endtask

    // random phases: new settings, knot and point reloads, evaluates, noise
    task automatic test_random_mix();
        int phase;
        int lu;
        int lv;
        phase = 0;
        while (beats_sent < BEAT_TARGET)
        begin
            // a few phases keep the biggest grid, most stay small
            lu = ($urandom_range(7) == 0) ? 15 : $urandom_range(1, 6);
            lv = ($urandom_range(7) == 0) ? 15 : $urandom_range(1, 6);
            set_config($urandom_range(1, 3), $urandom_range(1, 3), lu, lv);
            calm = (phase == 3);
            if ($urandom_range(2) == 0)
            begin
                load_knots(1'b0, ($urandom_range(5) == 0) ? 2 : $urandom_range(1));
            end
            if ($urandom_range(2) == 0)
            begin
                load_knots(1'b1, ($urandom_range(5) == 0) ? 2 : $urandom_range(1));
            end
            repeat (20)
            begin
                case ($urandom_range(9))
                    0, 1, 2:
                    begin
                        write_point($urandom_range(15), $urandom_range(15), rand_coord(),
                                    rand_coord(), rand_coord());
                    end
                    3:
                    begin
                        write_knot($urandom_range(1), $urandom_range(31),
                                   $urandom_range(65536));
                    end
                    default:
                    begin
                        evaluate(pick_param(1'b0), pick_param(1'b1));
                    end
                endcase
            end
            // sender holds off until every point is back, then resumes
            if (phase % 5 == 2)
            begin
                drain_results();
                evaluate(pick_param(1'b0), pick_param(1'b1));
            end
            calm = 1'b0;
            phase++;
        end
    endtask

    // ---------------------------------------------------------------
    // receiver side: random stall and result checking
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        out_stall <= !calm && rst_n && ($urandom_range(99) < 25);
    end

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch %s: expected %0d actual %0d at %0t", what, want, got, $realtime);
        end
    endtask

    always @(posedge clk)
    begin
        surf_pt_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                note_mismatch("unexpected surface point x", 0, surf_x);
            end
            else
            begin
                want = expected_points.pop_front();
                if (surf_x !== want.x)
                begin
                    note_mismatch("surf_x", want.x, surf_x);
                end
                if (surf_y !== want.y)
                begin
                    note_mismatch("surf_y", want.y, surf_y);
                end
                if (surf_z !== want.z)
                begin
                    note_mismatch("surf_z", want.z, surf_z);
                end
            end
        end
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bspline_surface_evaluate_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < KNOT_SLOTS; k++)
        begin
            u_knots[k] = 0;
            v_knots[k] = 0;
        end
        for (int k = 0; k < GRID*GRID; k++)
        begin
            grid_x[k] = 0;
            grid_y[k] = 0;
            grid_z[k] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_stores();
        test_directed_corners();
        test_config_extremes();
        test_random_mix();
        drain_results();
        if (mismatches == 0 && expected_points.size() == 0)
        begin
            $display("bspline_surface_evaluate_unit verification clean");
        end
        else
        begin
            $display("bspline_surface_evaluate_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
src/bse_pkg.sv
src/bse_ram.sv
src/bse_basis.sv
src/bspline_surface_evaluate_unit.sv
tb/tb_bspline_surface_evaluate_unit.sv
